// File: hdl/rgbk_pkg.sv
package rgbk_pkg;

  localparam int DIM_W      = 11;
  localparam int SEL_W      = 10;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_COL_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_ROW_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_COL_END   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_ROW_END   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_KIND   = 3'd6;

  localparam logic [KIND_W-1:0] KIND_EDGE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SHARPEN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BOX     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_GAUSS   = 2'd3;

  typedef struct packed {
    logic v;
    logic emit;
    logic interior;
    logic last;
  } pipe_t;

endpackage

// File: hdl/rgbk_ctrl.sv
module rgbk_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int CW = $clog2(MAX_WIDTH + 1),
  localparam int RW = $clog2(MAX_HEIGHT + 3),
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic                              is_padding,
  input  logic                              cfg_valid,
  input  logic [rgbk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbk_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              take,
  output logic                              pix_phase,
  output logic [AW-1:0]                     rd_addr,
  output logic [AW-1:0]                     s1_addr,
  output rgbk_pkg::pipe_t                   s1,
  output logic [rgbk_pkg::KIND_W-1:0]       kind
);

  logic [rgbk_pkg::DIM_W-1:0]  fw_r, fh_r, sce_r, sre_r;
  logic [rgbk_pkg::SEL_W-1:0]  scs_r, srs_r;
  logic [rgbk_pkg::KIND_W-1:0] kind_r;
  logic [CW-1:0]               col_r, col_nxt;
  logic [RW-1:0]               row_r, row_nxt;
  rgbk_pkg::pipe_t             s1_r, s1_nxt;
  logic [AW-1:0]               s1_addr_r;

  logic [CW-1:0] wd, c0, cc;
  logic [RW-1:0] ht, r0, cr;
  logic          ok, inter, last;

  always_comb begin
    if (fw_r == '0) begin
      wd = CW'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      wd = CW'(MAX_WIDTH);
    end else begin
      wd = CW'(fw_r);
    end
    if (fh_r == '0) begin
      ht = RW'(1);
    end else if (32'(fh_r) > MAX_HEIGHT) begin
      ht = RW'(MAX_HEIGHT);
    end else begin
      ht = RW'(fh_r);
    end

    c0 = col_r;
    r0 = row_r;
    if (col_r >= wd) begin
      c0 = '0;
      r0 = row_r + RW'(1);
    end
    if ((r0 > ht + RW'(1)) || ((r0 == ht + RW'(1)) && (c0 != '0))) begin
      c0 = '0;
      r0 = '0;
    end
    pix_phase = r0 < ht;
    take      = in_valid && adv && !(pix_phase && is_padding);

    col_nxt = c0 + CW'(1);
    row_nxt = r0;
    if (col_nxt >= wd) begin
      col_nxt = '0;
      row_nxt = r0 + RW'(1);
    end

    if (c0 == '0) begin
      ok = r0 >= RW'(2);
      cr = r0 - RW'(2);
      cc = wd - CW'(1);
    end else begin
      ok = r0 >= RW'(1);
      cr = r0 - RW'(1);
      cc = c0 - CW'(1);
    end
    ok    = ok && (cr < ht);
    inter = (cr >= RW'(1)) && (cc >= CW'(1)) &&
            (32'(cr) + 32'd1 < 32'(ht)) && (32'(cc) + 32'd1 < 32'(wd)) &&
            (32'(cc) >= 32'(scs_r)) && (32'(cc) < 32'(sce_r)) &&
            (32'(cr) >= 32'(srs_r)) && (32'(cr) < 32'(sre_r));
    last  = ok && (cr == ht - RW'(1)) && (cc == wd - CW'(1));
    if (last) begin
      col_nxt = '0;
      row_nxt = '0;
    end

    s1_nxt          = s1_r;
    if (adv) begin
      s1_nxt.v        = take;
      s1_nxt.emit     = take && ok;
      s1_nxt.interior = inter;
      s1_nxt.last     = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= rgbk_pkg::DIM_W'(1024);
      fh_r   <= rgbk_pkg::DIM_W'(1024);
      scs_r  <= '0;
      srs_r  <= '0;
      sce_r  <= rgbk_pkg::DIM_W'(1024);
      sre_r  <= rgbk_pkg::DIM_W'(1024);
      kind_r <= rgbk_pkg::KIND_EDGE;
      col_r  <= '0;
      row_r  <= '0;
      s1_r   <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rgbk_pkg::CFG_FRAME_WIDTH:   fw_r   <= cfg_data;
          rgbk_pkg::CFG_FRAME_HEIGHT:  fh_r   <= cfg_data;
          rgbk_pkg::CFG_SEL_COL_START: scs_r  <= cfg_data[rgbk_pkg::SEL_W-1:0];
          rgbk_pkg::CFG_SEL_ROW_START: srs_r  <= cfg_data[rgbk_pkg::SEL_W-1:0];
          rgbk_pkg::CFG_SEL_COL_END:   sce_r  <= cfg_data;
          rgbk_pkg::CFG_SEL_ROW_END:   sre_r  <= cfg_data;
          rgbk_pkg::CFG_FILTER_KIND:   kind_r <= cfg_data[rgbk_pkg::KIND_W-1:0];
          default: ;
        endcase
      end
      if (take) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end else if (in_valid && adv) begin
        // ignored padding item still settles the wrapped position
        col_r <= c0;
        row_r <= r0;
      end
      s1_r <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr_r <= c0[AW-1:0];
    end
  end

  assign rd_addr = c0[AW-1:0];
  assign s1_addr = s1_addr_r;
  assign s1      = s1_r;
  assign kind    = kind_r;

endmodule

// File: hdl/rgbk_lane.sv
module rgbk_lane #(
  parameter int MAX_WIDTH     = 1024,
  parameter int FRACTION_BITS = 14,
  localparam int SW = 8 + FRACTION_BITS,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                        clk,
  input  logic                        adv,
  input  logic                        take,
  input  logic [AW-1:0]               rd_addr,
  input  logic                        s1_v,
  input  logic [AW-1:0]               s1_addr,
  input  logic [SW-1:0]               sample_in,
  input  logic [rgbk_pkg::KIND_W-1:0] kind,
  output logic [SW-1:0]               filt,
  output logic [SW-1:0]               center
);

  localparam int SUMW = SW + 4;
  localparam int ACW  = SW + 6;
  localparam int SH   = SUMW + 4;
  localparam int MW   = SH - 2;
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'd8) / 64'd9;

  logic [2*SW-1:0] mem [0:MAX_WIDTH-1];
  logic [2*SW-1:0] rd_q_r;
  logic [SW-1:0]   smp_r;
  logic [SW-1:0]   win_r [0:2][0:2];

  logic [SW-1:0]   top, mid;
  logic [SW+1:0]   e_nxt, k_nxt;
  logic [SW-1:0]   c_r;
  logic [SW+1:0]   e_r, k_r;

  logic signed [ACW-1:0] cs, es, ks, acc_nxt;
  logic signed [ACW-1:0] acc_r;
  logic [SUMW-1:0]       sum_r;
  logic [SW-1:0]         cen_r;

  logic [SUMW+MW-1:0]    prod;
  logic signed [ACW-1:0] val;

  assign top = rd_q_r[2*SW-1:SW];
  assign mid = rd_q_r[SW-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_v) begin
        mem[s1_addr] <= {mid, smp_r};
      end
      if (take) begin
        smp_r <= sample_in;
        if (s1_v && (s1_addr == rd_addr)) begin
          rd_q_r <= {mid, smp_r};
        end else begin
          rd_q_r <= mem[rd_addr];
        end
      end
    end
  end

  // sums over the window as it stands after this item's column is shifted in
  always_comb begin
    e_nxt = (SW+2)'(win_r[2][0]) + (SW+2)'(win_r[1][1]) + (SW+2)'(mid) +
            (SW+2)'(win_r[2][2]);
    k_nxt = (SW+2)'(win_r[1][0]) + (SW+2)'(top) + (SW+2)'(win_r[1][2]) +
            (SW+2)'(smp_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_v) begin
        for (int r = 0; r < 3; r++) begin
          win_r[0][r] <= win_r[1][r];
          win_r[1][r] <= win_r[2][r];
        end
        win_r[2][0] <= top;
        win_r[2][1] <= mid;
        win_r[2][2] <= smp_r;
      end
      c_r <= win_r[2][1];
      e_r <= e_nxt;
      k_r <= k_nxt;
    end
  end

  always_comb begin
    cs = $signed(ACW'(c_r));
    es = $signed(ACW'(e_r));
    ks = $signed(ACW'(k_r));
    case (kind)
      rgbk_pkg::KIND_EDGE:    acc_nxt = (cs <<< 3) - es - ks;
      rgbk_pkg::KIND_SHARPEN: acc_nxt = (cs <<< 2) + cs - es;
      rgbk_pkg::KIND_GAUSS:   acc_nxt = ((cs <<< 2) + (es <<< 1) + ks) >>> 4;
      default:                acc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r <= acc_nxt;
      sum_r <= SUMW'(c_r) + SUMW'(e_r) + SUMW'(k_r);
      cen_r <= c_r;
    end
  end

  // divide by nine through a reciprocal, exact over the whole sum range
  always_comb begin
    prod = (SUMW+MW)'(sum_r) * (SUMW+MW)'(MW'(RECIP));
    if (kind == rgbk_pkg::KIND_BOX) begin
      val = $signed(ACW'(prod[SH +: SW+1]));
    end else begin
      val = acc_r;
    end
    if (val < 0) begin
      filt = '0;
    end else if (val > $signed(ACW'(255) <<< FRACTION_BITS)) begin
      filt = SW'(255) << FRACTION_BITS;
    end else begin
      filt = val[SW-1:0];
    end
  end

  assign center = cen_r;

endmodule

// File: hdl/rgb_3x3_kernel_filter.sv
// channel | direction | handshake                | payload
// in      | input     | in_valid / in_ready      | red, green, blue samples, padding flag
// out     | output    | out_valid / out_ready    | red, green, blue samples, frame_last
// cfg     | input     | cfg_valid / cfg_ready    | cfg_index, cfg_data
// One item per clock when out_ready is held high; four register stages from
// acceptance to out_valid (line store read, window, kernel, divide/saturate).
// A result leaves frame_width + 1 accepted items after its pixel.
// Synchronous active-low reset clears position and stage valids and restores
// config defaults; line stores and window need no clearing.
// Whole pipeline stalls while the output register is full and not taken.
module rgb_3x3_kernel_filter #(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_HEIGHT    = 1024,
  parameter int FRACTION_BITS = 14,
  localparam int SW = 8 + FRACTION_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [SW-1:0]                   in_red_in,
  input  logic [SW-1:0]                   in_green_in,
  input  logic [SW-1:0]                   in_blue_in,
  input  logic                            in_is_padding,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [SW-1:0]                   out_red_out,
  output logic [SW-1:0]                   out_green_out,
  output logic [SW-1:0]                   out_blue_out,
  output logic                            out_frame_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rgbk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbk_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic                        adv, take, pix_phase;
  logic [AW-1:0]               rd_addr, s1_addr;
  logic [rgbk_pkg::KIND_W-1:0] kind;
  rgbk_pkg::pipe_t             s1, s2_r, s3_r;
  logic [SW-1:0]               smp [0:2];
  logic [SW-1:0]               filt [0:2];
  logic [SW-1:0]               cen [0:2];
  logic                        out_valid_r, last_r;
  logic [SW-1:0]               pix_r [0:2];

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  rgbk_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .is_padding(in_is_padding),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .pix_phase (pix_phase),
    .rd_addr   (rd_addr),
    .s1_addr   (s1_addr),
    .s1        (s1),
    .kind      (kind)
  );

  assign smp[0] = pix_phase ? in_red_in   : '0;
  assign smp[1] = pix_phase ? in_green_in : '0;
  assign smp[2] = pix_phase ? in_blue_in  : '0;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    rgbk_lane #(
      .MAX_WIDTH    (MAX_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
    ) u_lane (
      .clk      (clk),
      .adv      (adv),
      .take     (take),
      .rd_addr  (rd_addr),
      .s1_v     (s1.v),
      .s1_addr  (s1_addr),
      .sample_in(smp[g]),
      .kind     (kind),
      .filt     (filt[g]),
      .center   (cen[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r        <= '0;
      s3_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_r        <= '{v: s1.v && s1.emit, emit: s1.emit, interior: s1.interior,
                       last: s1.last};
      s3_r        <= s2_r;
      out_valid_r <= s3_r.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_r <= s3_r.last;
      for (int i = 0; i < 3; i++) begin
        pix_r[i] <= s3_r.interior ? filt[i] : cen[i];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_out    = pix_r[0];
  assign out_green_out  = pix_r[1];
  assign out_blue_out   = pix_r[2];
  assign out_frame_last = last_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_s2_only_results: assert property (@(posedge clk) disable iff (!rst_n)
    s2_r.v |-> s2_r.emit)
    else $error("non-result item entered kernel stage");

  a_s3_feeds_output: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s3_r.v |=> out_valid)
    else $error("result lost between kernel and output");

endmodule

// File: tb/sv/rgb_3x3_kernel_filter_test.sv
`timescale 1ns / 1ps

module rgb_3x3_kernel_filter_test;

  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam logic [21:0] SAT_MAX = 22'd4177920;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_AT = 3000;
  localparam int HOLD_LEN = 400;

  typedef struct packed {
    logic [21:0] red;
    logic [21:0] green;
    logic [21:0] blue;
    logic        last;
  } pix_res_t;

  typedef struct {
    logic [21:0] red;
    logic [21:0] green;
    logic [21:0] blue;
    logic        pad;
    bit          typed;
    pix_res_t    want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [21:0] in_red_in;
  logic [21:0] in_green_in;
  logic [21:0] in_blue_in;
  logic in_is_padding;
  logic out_valid;
  logic out_ready;
  logic [21:0] out_red_out;
  logic [21:0] out_green_out;
  logic [21:0] out_blue_out;
  logic out_frame_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [rgbk_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rgbk_pkg::CFG_DATA_W-1:0] cfg_data;

  rgb_3x3_kernel_filter u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_red_in(in_red_in),
    .in_green_in(in_green_in),
    .in_blue_in(in_blue_in),
    .in_is_padding(in_is_padding),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_red_out(out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out(out_blue_out),
    .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // filter model state
  logic [21:0] line_st[3][2*MAXW];
  logic [21:0] taps[3][3][3];
  int unsigned pos_col, pos_row;
  int unsigned reg_w, reg_h, reg_csel0, reg_rsel0, reg_csel1, reg_rsel1;
  logic [1:0] reg_kind;

  pix_res_t pixels_due[$];
  int errors;
  int cycle_cnt;
  int burst_left;
  dir_row_t dir_rows[14];

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("rgb_3x3_kernel_filter test failed");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned top);
    if (v < 1) return 1;
    return (v > top) ? top : v;
  endfunction

  function automatic logic [21:0] kernel_chan(int c_i);
    longint c, e, k, acc;
    c = taps[c_i][1][1];
    e = longint'(taps[c_i][1][0]) + taps[c_i][0][1] + taps[c_i][2][1] + taps[c_i][1][2];
    k = longint'(taps[c_i][0][0]) + taps[c_i][2][0] + taps[c_i][0][2] + taps[c_i][2][2];
    case (reg_kind)
      rgbk_pkg::KIND_EDGE:    acc = 8 * c - e - k;
      rgbk_pkg::KIND_SHARPEN: acc = 5 * c - e;
      rgbk_pkg::KIND_BOX:     acc = (c + e + k) / 9;
      default:                acc = (4 * c + 2 * e + k) / 16;
    endcase
    if (acc < 0) acc = 0;
    if (acc > SAT_MAX) acc = SAT_MAX;
    return acc[21:0];
  endfunction

  // returns 1 when the item is taken into the frame, res_ok when a pixel is due
  function automatic bit filter_item(input logic [21:0] r, g, b, input logic pad,
                                     output bit res_ok, output pix_res_t res);
    int unsigned wd, ht, ic, ir, cr, cc;
    bit pixel_phase, inner;
    logic [21:0] smp[3];
    logic [21:0] v[3];
    res_ok = 0;
    res = '0;
    wd = clamp_dim(reg_w, MAXW);
    ht = clamp_dim(reg_h, MAXH);
    if (pos_col >= wd) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row > ht + 1 || (pos_row == ht + 1 && pos_col > 0)) begin
      pos_col = 0;
      pos_row = 0;
    end
    pixel_phase = pos_row < ht;
    if (pixel_phase && pad) return 0;
    ic = pos_col;
    ir = pos_row;
    smp[0] = pixel_phase ? r : '0;
    smp[1] = pixel_phase ? g : '0;
    smp[2] = pixel_phase ? b : '0;
    for (int c_i = 0; c_i < 3; c_i++) begin
      for (int x = 0; x < 2; x++)
        for (int y = 0; y < 3; y++) taps[c_i][x][y] = taps[c_i][x+1][y];
      taps[c_i][2][0] = line_st[c_i][MAXW + ic];
      taps[c_i][2][1] = line_st[c_i][ic];
      taps[c_i][2][2] = smp[c_i];
      line_st[c_i][MAXW + ic] = line_st[c_i][ic];
      line_st[c_i][ic] = smp[c_i];
    end
    pos_col = ic + 1;
    if (pos_col >= wd) begin
      pos_col = 0;
      pos_row = ir + 1;
    end
    if (ic == 0) begin
      if (ir < 2) return 1;
      cr = ir - 2;
      cc = wd - 1;
    end else begin
      if (ir < 1) return 1;
      cr = ir - 1;
      cc = ic - 1;
    end
    if (cr >= ht || cc >= wd) return 1;
    inner = cr >= 1 && cc >= 1 && cr + 1 < ht && cc + 1 < wd &&
            cc >= reg_csel0 && cc < reg_csel1 && cr >= reg_rsel0 && cr < reg_rsel1;
    for (int c_i = 0; c_i < 3; c_i++) v[c_i] = inner ? kernel_chan(c_i) : taps[c_i][1][1];
    res.red = v[0];
    res.green = v[1];
    res.blue = v[2];
    res.last = (cr == ht - 1 && cc == wd - 1);
    if (res.last) begin
      pos_col = 0;
      pos_row = 0;
    end
    res_ok = 1;
    return 1;
  endfunction

  task automatic report(input string what, input logic [21:0] got, input logic [21:0] want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        report("unexpected item", out_red_out, '0);
      end else begin
        pix_res_t w;
        w = pixels_due.pop_front();
        if (out_red_out !== w.red) report("red", out_red_out, w.red);
        if (out_green_out !== w.green) report("green", out_green_out, w.green);
        if (out_blue_out !== w.blue) report("blue", out_blue_out, w.blue);
        if (out_frame_last !== w.last)
          report("frame_last", 22'(out_frame_last), 22'(w.last));
      end
    end
  end

  // receiver
  initial begin
    int mode;
    out_ready = 1'b0;
    mode = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (cycle_cnt == HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        if (cycle_cnt % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 9) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic cfg_write(input logic [rgbk_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[rgbk_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rgbk_pkg::CFG_FRAME_WIDTH:   reg_w = val & 11'h7FF;
      rgbk_pkg::CFG_FRAME_HEIGHT:  reg_h = val & 11'h7FF;
      rgbk_pkg::CFG_SEL_COL_START: reg_csel0 = val & 10'h3FF;
      rgbk_pkg::CFG_SEL_ROW_START: reg_rsel0 = val & 10'h3FF;
      rgbk_pkg::CFG_SEL_COL_END:   reg_csel1 = val & 11'h7FF;
      rgbk_pkg::CFG_SEL_ROW_END:   reg_rsel1 = val & 11'h7FF;
      rgbk_pkg::CFG_FILTER_KIND:   reg_kind = val[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // returns whether the item counted as part of the frame
  task automatic send_item(input logic [21:0] r, g, b, input logic pad,
                           input bit typed, input pix_res_t want, output bit taken);
    bit res_ok;
    pix_res_t res;
    in_valid <= 1'b1;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    in_is_padding <= pad;
    do @(posedge clk); while (!in_ready);
    taken = filter_item(r, g, b, pad, res_ok, res);
    if (res_ok) pixels_due.push_back(typed ? want : res);
    if (--burst_left <= 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(posedge clk);
      else repeat (1) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
    end
  endtask

  function automatic logic [21:0] rand_sample();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3:    return SAT_MAX;
      4:       return 22'($urandom);
      default: return 22'($urandom_range(0, 4177920));
    endcase
  endfunction

  initial begin
    int counted, frame_no, wd, ht;
    int unsigned w_reg, h_reg;
    bit taken;
    pix_res_t none;
    none = '0;
    errors = 0;
    cycle_cnt = 0;
    burst_left = 8;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_red_in = '0;
    in_green_in = '0;
    in_blue_in = '0;
    in_is_padding = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int c_i = 0; c_i < 3; c_i++) begin
      for (int i = 0; i < 2 * MAXW; i++) line_st[c_i][i] = '0;
      for (int x = 0; x < 3; x++)
        for (int y = 0; y < 3; y++) taps[c_i][x][y] = '0;
    end
    pos_col = 0;
    pos_row = 0;
    reg_w = 1024;
    reg_h = 1024;
    reg_csel0 = 0;
    reg_rsel0 = 0;
    reg_csel1 = 1024;
    reg_rsel1 = 1024;
    reg_kind = rgbk_pkg::KIND_EDGE;

    // 3x3 frame, edge kernel: centre saturates, out-of-range corner passes
    dir_rows[0] = '{22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 1'b0, 0, none};
    dir_rows[1] = '{'0, '0, '0, 1'b0, 0, none};
    dir_rows[2] = '{'0, '0, '0, 1'b0, 0, none};
    dir_rows[3] = '{22'd777, 22'd777, 22'd777, 1'b1, 0, none};
    dir_rows[4] = '{'0, '0, '0, 1'b0, 0, none};
    dir_rows[5] = '{SAT_MAX, SAT_MAX, SAT_MAX, 1'b0, 1, '{22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 1'b0}};
    dir_rows[6] = '{'0, '0, '0, 1'b0, 1, none};
    dir_rows[7] = '{'0, '0, '0, 1'b0, 1, none};
    dir_rows[8] = '{'0, '0, '0, 1'b0, 1, none};
    dir_rows[9] = '{'0, '0, '0, 1'b0, 1, '{SAT_MAX, SAT_MAX, SAT_MAX, 1'b0}};
    dir_rows[10] = '{'0, '0, '0, 1'b1, 1, none};
    dir_rows[11] = '{22'd12345, 22'd54321, 22'd99, 1'b0, 1, none};
    dir_rows[12] = '{'0, '0, '0, 1'b1, 1, none};
    dir_rows[13] = '{'0, '0, '0, 1'b1, 1, '{'0, '0, '0, 1'b1}};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(rgbk_pkg::CFG_FRAME_WIDTH, 3);
    cfg_write(rgbk_pkg::CFG_FRAME_HEIGHT, 3);
    cfg_write(rgbk_pkg::CFG_FILTER_KIND, rgbk_pkg::KIND_EDGE);
    foreach (dir_rows[i])
      send_item(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue, dir_rows[i].pad,
                dir_rows[i].typed, dir_rows[i].want, taken);
    in_valid <= 1'b0;
    wait_drained();

    counted = 0;
    frame_no = 0;
    while (counted < 1000) begin
      case (frame_no)
        3: begin w_reg = 0; h_reg = 0; end
        6: begin w_reg = 0; h_reg = 2047; end
        default: begin
          w_reg = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
          h_reg = $urandom_range(0, 6);
        end
      endcase
      cfg_write(rgbk_pkg::CFG_FRAME_WIDTH, w_reg);
      cfg_write(rgbk_pkg::CFG_FRAME_HEIGHT, h_reg);
      wd = clamp_dim(w_reg, MAXW);
      ht = clamp_dim(h_reg, MAXH);
      cfg_write(rgbk_pkg::CFG_SEL_COL_START,
                ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(0, wd));
      cfg_write(rgbk_pkg::CFG_SEL_ROW_START,
                ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, ht));
      cfg_write(rgbk_pkg::CFG_SEL_COL_END,
                ($urandom_range(0, 7) == 0) ? 2047 : $urandom_range(1, wd + 1));
      cfg_write(rgbk_pkg::CFG_SEL_ROW_END,
                ($urandom_range(0, 7) == 0) ? 1024 : $urandom_range(1, ht + 1));
      cfg_write(rgbk_pkg::CFG_FILTER_KIND, $urandom_range(0, 3));
      for (int i = 0; i < wd * ht + wd + 1; ) begin
        if (i < wd * ht && $urandom_range(0, 19) == 0)
          send_item(22'($urandom), 22'($urandom), 22'($urandom), 1'b1, 0, none, taken);
        else if (i >= wd * ht && $urandom_range(0, 7) != 0)
          send_item(22'($urandom), 22'($urandom), 22'($urandom), 1'b1, 0, none, taken);
        else
          send_item(rand_sample(), rand_sample(), rand_sample(), 1'b0, 0, none, taken);
        if (taken) begin
          i++;
          counted++;
        end
      end
      in_valid <= 1'b0;
      wait_drained();
      frame_no++;
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pixels_due.size() == 0) begin
      $display("rgb_3x3_kernel_filter test passed");
    end else begin
      $display("rgb_3x3_kernel_filter test failed");
    end
    $finish;
  end

endmodule
